>>> design/msscc_pkg.sv
// Shared types and instruction codes for the MIPS subset core.
package msscc_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type function codes
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_NOR = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              reg_write;
        logic [REG_AW-1:0] reg_index;
        logic [XLEN-1:0]   reg_value;
        logic              is_load;
        logic              mem_write;
        logic [XLEN-1:0]   mem_value;
        logic              branch_taken;
        logic              unsupported;
    } t_res;

endpackage

>>> design/msscc_regfile.sv
// 32-entry register file with two registered read ports and write bypass.
module msscc_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [msscc_pkg::REG_AW-1:0]    i_rs,
    input  logic [msscc_pkg::REG_AW-1:0]    i_rt,
    input  logic                            i_wr_en,
    input  logic [msscc_pkg::REG_AW-1:0]    i_wr_idx,
    input  logic [msscc_pkg::XLEN-1:0]      i_wr_data,
    output logic [msscc_pkg::XLEN-1:0]      o_a,
    output logic [msscc_pkg::XLEN-1:0]      o_b
);

    logic [msscc_pkg::XLEN-1:0]      r_mem [msscc_pkg::REG_COUNT];
    logic [msscc_pkg::REG_COUNT-1:0] r_vld;
    logic [msscc_pkg::XLEN-1:0]      r_a;
    logic [msscc_pkg::XLEN-1:0]      r_b;
    logic [msscc_pkg::XLEN-1:0]      n_a;
    logic [msscc_pkg::XLEN-1:0]      n_b;

    // A held operand also picks up a write to its register.
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (i_rd_en) begin
            n_a = r_vld[i_rs] ? r_mem[i_rs] : '0;
            n_b = r_vld[i_rt] ? r_mem[i_rt] : '0;
        end
        if (i_wr_en && (i_wr_idx == i_rs)) begin
            n_a = i_wr_data;
        end
        if (i_wr_en && (i_wr_idx == i_rt)) begin
            n_b = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_a <= n_a;
        r_b <= n_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

>>> design/msscc_alu.sv
// Decode, ALU, branch and jump target, and load/store address generation.
module msscc_alu (
    input  logic [msscc_pkg::XLEN-1:0] i_instr,
    input  logic [msscc_pkg::XLEN-1:0] i_pc,
    input  logic [msscc_pkg::XLEN-1:0] i_a,
    input  logic [msscc_pkg::XLEN-1:0] i_b,
    output msscc_pkg::t_res            o_res,
    output logic [msscc_pkg::XLEN-3:0] o_word_addr
);

    logic [5:0]                       w_opc;
    logic [5:0]                       w_fn;
    logic [msscc_pkg::REG_AW-1:0]     w_rt;
    logic [msscc_pkg::REG_AW-1:0]     w_rd;
    logic [msscc_pkg::XLEN-1:0]       w_imm;
    logic [msscc_pkg::XLEN-1:0]       w_pc4;
    logic [msscc_pkg::XLEN-1:0]       w_addr;
    logic [msscc_pkg::XLEN-1:0]       w_npc;
    logic [msscc_pkg::XLEN-1:0]       w_rv;
    logic [msscc_pkg::REG_AW-1:0]     w_ri;
    logic                             w_rw;
    logic                             w_lw;
    logic                             w_sw;
    logic                             w_taken;
    logic                             w_bad;
    logic                             w_wr;

    assign w_opc  = i_instr[31:26];
    assign w_fn   = i_instr[5:0];
    assign w_rt   = i_instr[20:16];
    assign w_rd   = i_instr[15:11];
    assign w_imm  = {{16{i_instr[15]}}, i_instr[15:0]};
    assign w_pc4  = i_pc + 32'd4;
    assign w_addr = i_a + w_imm;

    always_comb begin
        w_npc   = w_pc4;
        w_rv    = '0;
        w_ri    = '0;
        w_rw    = 1'b0;
        w_lw    = 1'b0;
        w_sw    = 1'b0;
        w_taken = 1'b0;
        w_bad   = 1'b0;
        case (w_opc)
            msscc_pkg::OP_RTYPE: begin
                w_rw = 1'b1;
                w_ri = w_rd;
                case (w_fn)
                    msscc_pkg::FN_ADD: w_rv = i_a + i_b;
                    msscc_pkg::FN_SUB: w_rv = i_a - i_b;
                    msscc_pkg::FN_AND: w_rv = i_a & i_b;
                    msscc_pkg::FN_OR:  w_rv = i_a | i_b;
                    msscc_pkg::FN_NOR: w_rv = ~(i_a | i_b);
                    msscc_pkg::FN_SLT: w_rv = {31'd0, $signed(i_a) < $signed(i_b)};
                    default: begin
                        w_rw  = 1'b0;
                        w_bad = 1'b1;
                    end
                endcase
            end
            msscc_pkg::OP_LW: begin
                w_rw = 1'b1;
                w_ri = w_rt;
                w_lw = 1'b1;
            end
            msscc_pkg::OP_SW: begin
                w_sw = 1'b1;
            end
            msscc_pkg::OP_BEQ: begin
                if (i_a == i_b) begin
                    w_taken = 1'b1;
                    w_npc   = w_pc4 + {w_imm[29:0], 2'b00};
                end
            end
            msscc_pkg::OP_J: begin
                w_taken = 1'b1;
                w_npc   = {w_pc4[31:28], i_instr[25:0], 2'b00};
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    // Register zero is never written.
    assign w_wr = w_rw && (w_ri != '0);

    always_comb begin
        o_res.next_pc      = w_npc;
        o_res.reg_write    = w_wr;
        o_res.reg_index    = w_wr ? w_ri : '0;
        o_res.reg_value    = w_wr ? w_rv : '0;
        o_res.is_load      = w_wr && w_lw;
        o_res.mem_write    = w_sw;
        o_res.mem_value    = w_sw ? i_b : '0;
        o_res.branch_taken = w_taken;
        o_res.unsupported  = w_bad;
    end

    assign o_word_addr = w_addr[31:2];

endmodule

>>> design/msscc_dmem.sv
// Data memory with registered read and a zero-fill sweep after reset.
module msscc_dmem #(
    parameter int DATA_WORDS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic                              i_rd_en,
    input  logic [$clog2(DATA_WORDS)-1:0]     i_idx,
    input  logic [msscc_pkg::XLEN-1:0]        i_wdata,
    output logic [msscc_pkg::XLEN-1:0]        o_rdata,
    output logic                              o_busy
);

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DATA_WORDS - 1);

    logic [msscc_pkg::XLEN-1:0] r_mem [DATA_WORDS];
    logic [msscc_pkg::XLEN-1:0] r_q;
    logic                       r_busy;
    logic [IDX_W-1:0]           r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            if (r_clr == LAST) begin
                r_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_idx] <= i_wdata;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_idx];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_busy;

endmodule

>>> design/mips_subset_single_cycle_core_top.sv
// Top level of the MIPS subset core: operand, address, memory and result stages.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  in       | i_valid / o_stall  | i_instr_word
//  out      | o_valid / i_stall  | o_next_pc, o_reg_write, o_reg_index, o_reg_value,
//           |                    | o_mem_write, o_mem_word, o_mem_value,
//           |                    | o_branch_taken, o_unsupported
//
// One instruction per cycle unless a load hazard, output stall or the post-reset
// zero-fill of data memory (o_stall high) holds it; a result passes the operand,
// address, memory and result stages before it is offered. A reader of a register
// loaded by one of the two lw just ahead waits in the operand stage for the data.
// A stalled output holds full stages up to the first empty one; empty stages fill.
module mips_subset_single_cycle_core_top #(
    parameter int DATA_WORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_instr_word,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_mem_write,
    output logic [4:0]  o_mem_word,
    output logic [31:0] o_mem_value,
    output logic        o_branch_taken,
    output logic        o_unsupported
);

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam int RW    = IDX_W + 1;
    localparam longint unsigned RECIP = 64'h1_0000_0000 / DATA_WORDS;
    localparam logic [RW-1:0] DW_C = RW'(DATA_WORDS);

    // Pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_accept;
    logic w_hazard;
    logic w_busy;

    // Operand stage
    logic [31:0]           r_s1_instr;
    logic [31:0]           r_pc;
    logic [4:0]            w_rs, w_rt;
    logic [4:0]            w_rd_rs, w_rd_rt;
    logic [31:0]           w_rf_a, w_rf_b;
    logic [31:0]           w_opa, w_opb;
    msscc_pkg::t_res       w_s1_res;
    logic [29:0]           w_s1_waddr;

    // Address reduction and memory stages
    msscc_pkg::t_res       r_s2_res, r_s3_res, r_s4_res;
    logic [29:0]           r_s2_x;
    logic [61:0]           w_s2_prod;
    logic [RW-1:0]         r_s3_xlo, r_s3_qlo;
    logic [RW-1:0]         w_s3_qd, w_s3_rem, w_s3_fix;
    logic [IDX_W-1:0]      w_s3_idx;
    logic [IDX_W-1:0]      r_s4_idx;
    logic [31:0]           w_mem_q;
    logic [31:0]           w_out_value;
    logic                  w_wb;

    // Handshake chain, back to front
    assign w_rdy4   = !r_v4 || !i_stall;
    assign w_adv3   = r_v3 && w_rdy4;
    assign w_rdy3   = !r_v3 || w_adv3;
    assign w_adv2   = r_v2 && w_rdy3;
    assign w_rdy2   = !r_v2 || w_adv2;
    assign w_adv1   = r_v1 && w_rdy2 && !w_hazard;
    assign w_rdy1   = !r_v1 || w_adv1;
    assign o_stall  = w_busy || !w_rdy1;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_pc <= '0;
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_adv1) begin
                r_v1 <= 1'b0;
            end
            if (w_adv1) begin
                r_v2 <= 1'b1;
                r_pc <= w_s1_res.next_pc;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
            if (w_adv2) begin
                r_v3 <= 1'b1;
            end else if (w_adv3) begin
                r_v3 <= 1'b0;
            end
            if (w_adv3) begin
                r_v4 <= 1'b1;
            end else if (w_rdy4) begin
                r_v4 <= 1'b0;
            end
        end
    end

    // Register write-back at output transfer
    assign w_out_value = r_s4_res.is_load ? w_mem_q : r_s4_res.reg_value;
    assign w_wb        = r_v4 && !i_stall && r_s4_res.reg_write;

    assign w_rs    = r_s1_instr[25:21];
    assign w_rt    = r_s1_instr[20:16];
    assign w_rd_rs = w_accept ? i_instr_word[25:21] : w_rs;
    assign w_rd_rt = w_accept ? i_instr_word[20:16] : w_rt;

    msscc_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rs      (w_rd_rs),
        .i_rt      (w_rd_rt),
        .i_wr_en   (w_wb),
        .i_wr_idx  (r_s4_res.reg_index),
        .i_wr_data (w_out_value),
        .o_a       (w_rf_a),
        .o_b       (w_rf_b)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_instr <= i_instr_word;
        end
    end

    // Forward from younger stages first; hold on a pending load.
    always_comb begin
        w_opa = w_rf_a;
        if (r_v4 && r_s4_res.reg_write && (r_s4_res.reg_index == w_rs)) begin
            w_opa = w_out_value;
        end
        if (r_v3 && r_s3_res.reg_write && (r_s3_res.reg_index == w_rs)) begin
            w_opa = r_s3_res.reg_value;
        end
        if (r_v2 && r_s2_res.reg_write && (r_s2_res.reg_index == w_rs)) begin
            w_opa = r_s2_res.reg_value;
        end
        w_opb = w_rf_b;
        if (r_v4 && r_s4_res.reg_write && (r_s4_res.reg_index == w_rt)) begin
            w_opb = w_out_value;
        end
        if (r_v3 && r_s3_res.reg_write && (r_s3_res.reg_index == w_rt)) begin
            w_opb = r_s3_res.reg_value;
        end
        if (r_v2 && r_s2_res.reg_write && (r_s2_res.reg_index == w_rt)) begin
            w_opb = r_s2_res.reg_value;
        end
    end

    assign w_hazard =
        (r_v2 && r_s2_res.is_load &&
            ((r_s2_res.reg_index == w_rs) || (r_s2_res.reg_index == w_rt))) ||
        (r_v3 && r_s3_res.is_load &&
            ((r_s3_res.reg_index == w_rs) || (r_s3_res.reg_index == w_rt)));

    msscc_alu u_alu (
        .i_instr     (r_s1_instr),
        .i_pc        (r_pc),
        .i_a         (w_opa),
        .i_b         (w_opb),
        .o_res       (w_s1_res),
        .o_word_addr (w_s1_waddr)
    );

    // Word index mod DATA_WORDS: reciprocal estimate, then one correction.
    assign w_s2_prod = {32'd0, r_s2_x} * {30'd0, RECIP[31:0]};
    assign w_s3_qd   = RW'(r_s3_qlo * DW_C);
    assign w_s3_rem  = r_s3_xlo - w_s3_qd;
    assign w_s3_fix  = (w_s3_rem >= DW_C) ? (w_s3_rem - DW_C) : w_s3_rem;
    assign w_s3_idx  = IDX_W'(w_s3_fix);

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s2_res <= w_s1_res;
            r_s2_x   <= w_s1_waddr;
        end
        if (w_adv2) begin
            r_s3_res <= r_s2_res;
            r_s3_xlo <= r_s2_x[RW-1:0];
            r_s3_qlo <= w_s2_prod[32 +: RW];
        end
        if (w_adv3) begin
            r_s4_res <= r_s3_res;
            r_s4_idx <= w_s3_idx;
        end
    end

    msscc_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_adv3 && r_s3_res.mem_write),
        .i_rd_en (w_adv3 && r_s3_res.is_load),
        .i_idx   (w_s3_idx),
        .i_wdata (r_s3_res.mem_value),
        .o_rdata (w_mem_q),
        .o_busy  (w_busy)
    );

    assign o_valid        = r_v4;
    assign o_next_pc      = r_s4_res.next_pc;
    assign o_reg_write    = r_s4_res.reg_write;
    assign o_reg_index    = r_s4_res.reg_index;
    assign o_reg_value    = w_out_value;
    assign o_mem_write    = r_s4_res.mem_write;
    assign o_mem_word     = r_s4_res.mem_write ? 5'(r_s4_idx) : 5'd0;
    assign o_mem_value    = r_s4_res.mem_value;
    assign o_branch_taken = r_s4_res.branch_taken;
    assign o_unsupported  = r_s4_res.unsupported;

endmodule
